// File: rtl/jmcs_pkg.sv
// Shared constants and types for the JPEG marker carving scanner.
package jmcs_pkg;

  // Address and cluster counter widths.
  localparam int unsigned ADDR_BITS          = 48;
  localparam int unsigned CLUSTER_COUNT_BITS = 20;
  localparam int unsigned OFFSET_BITS        = 16;

  // Configuration port geometry: 64-bit registers at 8-byte strides.
  localparam int unsigned APB_DATA_BITS = 64;
  localparam int unsigned APB_ADDR_BITS = 5;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    RegClusterBytes  = 2'd0,
    RegPartitionBase = 2'd1,
    RegClusterLimit  = 2'd2,
    RegUnused        = 2'd3
  } reg_index_e;

  // Reset values of the configuration registers.
  localparam logic [OFFSET_BITS-1:0]        ClusterBytesRst = 16'd4096;
  localparam logic [CLUSTER_COUNT_BITS-1:0] ClusterLimitRst = CLUSTER_COUNT_BITS'(250000);

  // Marker byte values.
  localparam logic [7:0] MarkerLead = 8'hFF;
  localparam logic [7:0] MarkerSoi  = 8'hD8;
  localparam logic [7:0] MarkerApp0 = 8'hE0;
  localparam logic [7:0] MarkerEoi  = 8'hD9;

  // Event kinds.
  typedef enum logic {
    EventStart = 1'b0,
    EventEnd   = 1'b1
  } event_kind_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [OFFSET_BITS-1:0]        cluster_bytes;
    logic [ADDR_BITS-1:0]          partition_base;
    logic [CLUSTER_COUNT_BITS-1:0] cluster_limit;
  } cfg_t;

  // A matched marker leaving the scanner, address relative to the partition.
  typedef struct packed {
    event_kind_e                   kind;
    logic [ADDR_BITS-1:0]          rel_addr;
    logic [CLUSTER_COUNT_BITS-1:0] cluster;
    logic [OFFSET_BITS-1:0]        offset;
  } scan_event_t;

endpackage

// File: rtl/jmcs_regs.sv
// Configuration register file behind the APB-style port.
module jmcs_regs import jmcs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  logic [OFFSET_BITS-1:0]        cluster_bytes_q;
  logic [ADDR_BITS-1:0]          partition_base_q;
  logic [CLUSTER_COUNT_BITS-1:0] cluster_limit_q;
  reg_index_e                    reg_idx;
  logic                          wr_en;

  assign reg_idx = reg_index_e'(paddr[APB_ADDR_BITS-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_bytes_q  <= ClusterBytesRst;
      partition_base_q <= '0;
      cluster_limit_q  <= ClusterLimitRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegClusterBytes:  cluster_bytes_q  <= pwdata[OFFSET_BITS-1:0];
        RegPartitionBase: partition_base_q <= pwdata[ADDR_BITS-1:0];
        RegClusterLimit:  cluster_limit_q  <= pwdata[CLUSTER_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux; the unused slot reads as zero.
  always_comb begin
    case (reg_idx)
      RegClusterBytes:  prdata = APB_DATA_BITS'(cluster_bytes_q);
      RegPartitionBase: prdata = APB_DATA_BITS'(partition_base_q);
      RegClusterLimit:  prdata = APB_DATA_BITS'(cluster_limit_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.cluster_bytes  = cluster_bytes_q;
  assign cfg_o.partition_base = partition_base_q;
  assign cfg_o.cluster_limit  = cluster_limit_q;

endmodule

// File: rtl/jmcs_scan.sv
// Byte window, cluster tracking and marker matching for the scanner.
module jmcs_scan import jmcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        take_i,
  input  logic [7:0]  data_byte_i,
  output logic        hit_o,
  output scan_event_t event_o
);

  logic [23:0]                   recent_q;
  logic                          inside_q;
  logic                          skip_q;
  logic [OFFSET_BITS-1:0]        off_q;
  logic [CLUSTER_COUNT_BITS-1:0] cnt_q;
  logic [ADDR_BITS-1:0]          csa_q;

  logic [OFFSET_BITS:0]   eff;
  logic [OFFSET_BITS:0]   off_p1;
  logic [OFFSET_BITS:0]   off_p3;
  logic                   active;
  logic                   soi_hit;
  logic                   eoi_hit;
  logic                   cluster_end;
  logic [OFFSET_BITS-1:0] start_off;

  // A zero size register means a full 64 KiB cluster.
  assign eff    = (cfg_i.cluster_bytes == '0) ? {1'b1, {OFFSET_BITS{1'b0}}}
                                              : {1'b0, cfg_i.cluster_bytes};
  assign off_p1 = {1'b0, off_q} + (OFFSET_BITS+1)'(1);
  assign off_p3 = {1'b0, off_q} + (OFFSET_BITS+1)'(3);
  assign active = cnt_q < cfg_i.cluster_limit;

  // The marker's first byte must sit more than four bytes before the cluster end.
  assign soi_hit = !inside_q && (off_q >= OFFSET_BITS'(3))
                   && (recent_q == {MarkerLead, MarkerSoi, MarkerLead})
                   && (data_byte_i == MarkerApp0) && (off_p1 < eff);
  assign eoi_hit = inside_q && (off_q >= OFFSET_BITS'(1))
                   && (recent_q[7:0] == MarkerLead)
                   && (data_byte_i == MarkerEoi) && (off_p3 < eff);

  assign hit_o       = active && !skip_q && (soi_hit || eoi_hit);
  assign cluster_end = off_p1 >= eff;
  assign start_off   = inside_q ? off_q - OFFSET_BITS'(1) : off_q - OFFSET_BITS'(3);

  assign event_o.kind     = inside_q ? EventEnd : EventStart;
  assign event_o.rel_addr = csa_q + ADDR_BITS'(start_off);
  assign event_o.cluster  = cnt_q;
  assign event_o.offset   = start_off;

  // Scan state advances on every accepted byte below the cluster limit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      inside_q <= 1'b0;
      skip_q   <= 1'b0;
      off_q    <= '0;
      cnt_q    <= '0;
      csa_q    <= '0;
    end else if (take_i && active) begin
      recent_q <= {recent_q[15:0], data_byte_i};
      if (hit_o) begin
        inside_q <= !inside_q;
      end
      if (cluster_end) begin
        off_q  <= '0;
        csa_q  <= csa_q + ADDR_BITS'(eff);
        cnt_q  <= cnt_q + CLUSTER_COUNT_BITS'(1);
        skip_q <= 1'b0;
      end else begin
        off_q <= off_p1[OFFSET_BITS-1:0];
        if (hit_o) begin
          skip_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/jmcs_report.sv
// Event pipeline: absolute address, image size and the output register.
module jmcs_report import jmcs_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ADDR_BITS-1:0]          partition_base_i,
  input  logic                          ev_valid_i,
  input  scan_event_t                   ev_i,
  output logic                          ev_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          event_kind_o,
  output logic [ADDR_BITS-1:0]          marker_address_o,
  output logic [CLUSTER_COUNT_BITS-1:0] cluster_number_o,
  output logic [OFFSET_BITS-1:0]        cluster_offset_o,
  output logic [ADDR_BITS-1:0]          image_size_o
);

  // Stage one holds the relative event, stage two the absolute address.
  logic                          s1_valid_q;
  scan_event_t                   s1_q;
  logic                          s2_valid_q;
  event_kind_e                   s2_kind_q;
  logic [ADDR_BITS-1:0]          s2_addr_q;
  logic [CLUSTER_COUNT_BITS-1:0] s2_cluster_q;
  logic [OFFSET_BITS-1:0]        s2_offset_q;
  logic [ADDR_BITS-1:0]          img_start_q;
  logic                          out_valid_q;
  event_kind_e                   out_kind_q;
  logic [ADDR_BITS-1:0]          out_addr_q;
  logic [CLUSTER_COUNT_BITS-1:0] out_cluster_q;
  logic [OFFSET_BITS-1:0]        out_offset_q;
  logic [ADDR_BITS-1:0]          out_size_q;

  logic out_free;
  logic s2_free;
  logic s1_free;
  logic s1_move;
  logic s2_move;
  logic [ADDR_BITS-1:0] abs_addr;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign s1_move    = s1_valid_q && s2_free;
  assign s2_move    = s2_valid_q && out_free;
  assign ev_ready_o = s1_free;
  assign abs_addr   = partition_base_i + s1_q.rel_addr;

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      img_start_q <= '0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= ev_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
      // A start event records where the current image begins.
      if (s1_move && (s1_q.kind == EventStart)) begin
        img_start_q <= abs_addr;
      end
    end
  end

  // Payload registers load when their stage advances.
  always_ff @(posedge clk_i) begin
    if (s1_free && ev_valid_i) begin
      s1_q <= ev_i;
    end
    if (s1_move) begin
      s2_kind_q    <= s1_q.kind;
      s2_addr_q    <= abs_addr;
      s2_cluster_q <= s1_q.cluster;
      s2_offset_q  <= s1_q.offset;
    end
    if (s2_move) begin
      out_kind_q    <= s2_kind_q;
      out_addr_q    <= s2_addr_q;
      out_cluster_q <= s2_cluster_q;
      out_offset_q  <= s2_offset_q;
      out_size_q    <= (s2_kind_q == EventEnd) ? s2_addr_q - img_start_q : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = out_kind_q;
  assign marker_address_o = out_addr_q;
  assign cluster_number_o = out_cluster_q;
  assign cluster_offset_o = out_offset_q;
  assign image_size_o     = out_size_q;

endmodule

// File: rtl/jpeg_marker_carving_scanner.sv
// Top level of the JPEG marker carving scanner.
//
// Disk image bytes enter on the input channel (data_byte_i, in_valid_i,
// in_ready_o), one per transaction, in address order. Each byte moves the
// cluster offset, cluster index and cluster address; outside an image the
// scanner looks for FF D8 FF E0, inside one for FF D9, and after a match it
// skips the rest of that cluster. A match leaves on the output channel
// (out_valid_o, out_ready_i) with its kind, absolute address, cluster,
// offset and, for an end marker, the image size.
// The byte completing a marker loads its event into stage one when it is
// taken; the event then moves to stage two and to the output register.
// Throughput is one byte per cycle while in_ready_o is high; the byte path
// is the window compare and the offset counter, and events flow through a
// three-register pipeline (relative address, base add, size subtract).
// When the receiver stalls, events queue in the three stages and input
// transactions keep being taken until all three hold an event.
// Reset clears the scan state and the pipeline and loads the register
// defaults: 4096-byte clusters, partition base 0, limit 250000 clusters.
// The user must write registers over the APB-style port while idle; not enforced.
module jpeg_marker_carving_scanner import jmcs_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [APB_DATA_BITS-1:0]      pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          event_kind_o,
  output logic [ADDR_BITS-1:0]          marker_address_o,
  output logic [CLUSTER_COUNT_BITS-1:0] cluster_number_o,
  output logic [OFFSET_BITS-1:0]        cluster_offset_o,
  output logic [ADDR_BITS-1:0]          image_size_o
);

  cfg_t        cfg;
  logic        take;
  logic        hit;
  scan_event_t scan_event;
  logic        ev_ready;

  assign in_ready_o = ev_ready;
  assign take       = in_valid_i && ev_ready;

  // Configuration registers.
  jmcs_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Byte window and cluster tracking.
  jmcs_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .take_i     (take),
    .data_byte_i(data_byte_i),
    .hit_o      (hit),
    .event_o    (scan_event)
  );

  // Event pipeline and output register.
  jmcs_report u_report (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .partition_base_i(cfg.partition_base),
    .ev_valid_i      (take && hit),
    .ev_i            (scan_event),
    .ev_ready_o      (ev_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .marker_address_o(marker_address_o),
    .cluster_number_o(cluster_number_o),
    .cluster_offset_o(cluster_offset_o),
    .image_size_o    (image_size_o)
  );

  // Input stalls only when every pipeline stage, the output included, is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while the output register is empty");

  // Start events never carry an image size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_kind_o == EventStart)) |-> (image_size_o == '0))
    else $error("start event with nonzero image size");

  // A counted marker starts more than four bytes before the end of a 64 KiB cluster.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cluster_offset_o <= OFFSET_BITS'(65531)))
    else $error("marker offset too close to the cluster end");

endmodule
